// ===== rtl/planar_pose_compose_invert_defines.svh =====
// ----------------------------------------------------------------------------
// planar pose compose/invert assertion macros
// shared property forms for the port-level checker
// ----------------------------------------------------------------------------
`ifndef PLANAR_POSE_COMPOSE_INVERT_DEFINES_SVH
`define PLANAR_POSE_COMPOSE_INVERT_DEFINES_SVH

// same-cycle implication, off during reset
`define PPCI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define PPCI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset too
`define PPCI_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ppci_pkg.sv =====
// ----------------------------------------------------------------------------
// ppci_pkg
// types, constants and the arctangent table of the pose compose/invert pipe
// ----------------------------------------------------------------------------
package ppci_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int ATAN_ENTRIES = 30;
  localparam int N_CELLS      = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
  localparam int CW           = 34;
  localparam int SHW          = 5;
  localparam int TRIG_FRAC    = 30;
  localparam int PW           = CW + 32;
  localparam int SW           = PW + 1;
  localparam int RW           = SW - TRIG_FRAC;
  localparam int FW           = RW + 1;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [SW-1:0] ROUND_HALF  = SW'(64'sd1 <<< (TRIG_FRAC - 1));
  localparam logic signed [FW-1:0] POS_MAX     = FW'(64'sd2147483647);
  localparam logic signed [FW-1:0] POS_MIN     = FW'(-64'sd2147483648);

  typedef enum logic {
    OP_COMPOSE = 1'b0,
    OP_INVERT  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } rot_t;

  typedef struct packed {
    op_t                op;
    logic               flip;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [31:0]        r_right;
    logic [31:0]        r_left;
  } carry_t;

  function automatic logic signed [CW-1:0] atan_lut(input logic [SHW-1:0] idx);
    logic signed [CW-1:0] v;
    unique case (idx)
      5'd0:    v = 34'sh020000000;
      5'd1:    v = 34'sh012E4051E;
      5'd2:    v = 34'sh009FB385B;
      5'd3:    v = 34'sh0051111D4;
      5'd4:    v = 34'sh0028B0D43;
      5'd5:    v = 34'sh00145D7E1;
      5'd6:    v = 34'sh000A2F61E;
      5'd7:    v = 34'sh000517C55;
      5'd8:    v = 34'sh00028BE53;
      5'd9:    v = 34'sh000145F2F;
      5'd10:   v = 34'sh0000A2F98;
      5'd11:   v = 34'sh0000517CC;
      5'd12:   v = 34'sh000028BE6;
      5'd13:   v = 34'sh0000145F3;
      5'd14:   v = 34'sh000000A2FA;
      5'd15:   v = 34'sh00000517D;
      5'd16:   v = 34'sh0000028BE;
      5'd17:   v = 34'sh00000145F;
      5'd18:   v = 34'sh000000A30;
      5'd19:   v = 34'sh000000518;
      5'd20:   v = 34'sh00000028C;
      5'd21:   v = 34'sh000000146;
      5'd22:   v = 34'sh0000000A3;
      5'd23:   v = 34'sh000000051;
      5'd24:   v = 34'sh000000029;
      5'd25:   v = 34'sh000000014;
      5'd26:   v = 34'sh00000000A;
      5'd27:   v = 34'sh000000005;
      5'd28:   v = 34'sh000000003;
      5'd29:   v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ppci_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ppci_cordic_cell
// one rotation-mode cordic iteration with its own handshake register
// ----------------------------------------------------------------------------
module ppci_cordic_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ppci_pkg::SHW-1:0]      shift_i,
  input  logic signed [ppci_pkg::CW-1:0] atan_i,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ppci_pkg::rot_t                in_rot,
  input  ppci_pkg::carry_t              in_carry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ppci_pkg::rot_t                out_rot,
  output ppci_pkg::carry_t              out_carry
);
  import ppci_pkg::*;

  logic                 valid_r;
  rot_t                 rot_r;
  rot_t                 rot_nxt;
  carry_t               carry_r;
  logic                 adv;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;

  always_comb begin
    x  = in_rot.x;
    y  = in_rot.y;
    z  = in_rot.z;
    dx = y >>> shift_i;
    dy = x >>> shift_i;
    if (z[CW-1]) begin
      rot_nxt.x = x + dx;
      rot_nxt.y = y - dy;
      rot_nxt.z = z + atan_i;
    end else begin
      rot_nxt.x = x - dx;
      rot_nxt.y = y + dy;
      rot_nxt.z = z - atan_i;
    end
  end

  assign adv       = !valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r;
  assign out_rot   = rot_r;
  assign out_carry = carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      rot_r   <= rot_nxt;
      carry_r <= in_carry;
    end
  end

endmodule

// ===== rtl/ppci_mul_stage.sv =====
// ----------------------------------------------------------------------------
// ppci_mul_stage
// quadrant fix of cosine/sine and the four position products
// ----------------------------------------------------------------------------
module ppci_mul_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ppci_pkg::rot_t                in_rot,
  input  ppci_pkg::carry_t              in_carry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ppci_pkg::PW-1:0] out_pca,
  output logic signed [ppci_pkg::PW-1:0] out_psb,
  output logic signed [ppci_pkg::PW-1:0] out_psa,
  output logic signed [ppci_pkg::PW-1:0] out_pcb,
  output ppci_pkg::carry_t              out_carry
);
  import ppci_pkg::*;

  logic                 valid_r;
  logic signed [PW-1:0] pca_r;
  logic signed [PW-1:0] psb_r;
  logic signed [PW-1:0] psa_r;
  logic signed [PW-1:0] pcb_r;
  carry_t               carry_r;
  logic signed [CW-1:0] c;
  logic signed [CW-1:0] s;
  logic signed [31:0]   a;
  logic signed [31:0]   b;
  logic                 adv;

  always_comb begin
    c = in_carry.flip ? -in_rot.x : in_rot.x;
    s = in_carry.flip ? -in_rot.y : in_rot.y;
    a = in_carry.a;
    b = in_carry.b;
  end

  assign adv       = !valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r;
  assign out_pca   = pca_r;
  assign out_psb   = psb_r;
  assign out_psa   = psa_r;
  assign out_pcb   = pcb_r;
  assign out_carry = carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      pca_r   <= c * a;
      psb_r   <= s * b;
      psa_r   <= s * a;
      pcb_r   <= c * b;
      carry_r <= in_carry;
    end
  end

endmodule

// ===== rtl/ppci_round_stage.sv =====
// ----------------------------------------------------------------------------
// ppci_round_stage
// sums of products and round-half-up back to the position format
// ----------------------------------------------------------------------------
module ppci_round_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ppci_pkg::PW-1:0] in_pca,
  input  logic signed [ppci_pkg::PW-1:0] in_psb,
  input  logic signed [ppci_pkg::PW-1:0] in_psa,
  input  logic signed [ppci_pkg::PW-1:0] in_pcb,
  input  ppci_pkg::carry_t              in_carry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ppci_pkg::RW-1:0] out_rot_x,
  output logic signed [ppci_pkg::RW-1:0] out_rot_y,
  output ppci_pkg::carry_t              out_carry
);
  import ppci_pkg::*;

  logic                 valid_r;
  logic signed [RW-1:0] rot_x_r;
  logic signed [RW-1:0] rot_y_r;
  carry_t               carry_r;
  logic signed [SW-1:0] pca;
  logic signed [SW-1:0] psb;
  logic signed [SW-1:0] psa;
  logic signed [SW-1:0] pcb;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] rnd_x;
  logic signed [SW-1:0] rnd_y;
  logic                 adv;

  always_comb begin
    pca = SW'(in_pca);
    psb = SW'(in_psb);
    psa = SW'(in_psa);
    pcb = SW'(in_pcb);
    unique case (in_carry.op)
      OP_COMPOSE: begin
        sum_x = pca - psb;
        sum_y = psa + pcb;
      end
      OP_INVERT: begin
        sum_x = pca + psb;
        sum_y = pcb - psa;
      end
      default: begin
        sum_x = pca - psb;
        sum_y = psa + pcb;
      end
    endcase
    rnd_x = sum_x + ROUND_HALF;
    rnd_y = sum_y + ROUND_HALF;
  end

  assign adv       = !valid_r || out_ready;
  assign in_ready  = adv;
  assign out_valid = valid_r;
  assign out_rot_x = rot_x_r;
  assign out_rot_y = rot_y_r;
  assign out_carry = carry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      rot_x_r <= rnd_x[SW-1:TRIG_FRAC];
      rot_y_r <= rnd_y[SW-1:TRIG_FRAC];
      carry_r <= in_carry;
    end
  end

endmodule

// ===== rtl/ppci_sat_stage.sv =====
// ----------------------------------------------------------------------------
// ppci_sat_stage
// final offset or negation, saturation and the result register
// ----------------------------------------------------------------------------
module ppci_sat_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [ppci_pkg::RW-1:0] in_rot_x,
  input  logic signed [ppci_pkg::RW-1:0] in_rot_y,
  input  ppci_pkg::carry_t              in_carry,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_rx,
  output logic signed [31:0]            out_ry,
  output logic [31:0]                   out_r_right,
  output logic [31:0]                   out_r_left,
  output logic                          out_saturated
);
  import ppci_pkg::*;

  logic                 valid_r;
  logic signed [31:0]   rx_r;
  logic signed [31:0]   ry_r;
  logic [31:0]          r_right_r;
  logic [31:0]          r_left_r;
  logic                 sat_r;
  logic signed [FW-1:0] px;
  logic signed [FW-1:0] py;
  logic signed [31:0]   rx_nxt;
  logic signed [31:0]   ry_nxt;
  logic                 sat_x;
  logic                 sat_y;
  logic                 adv;

  always_comb begin
    unique case (in_carry.op)
      OP_COMPOSE: begin
        px = FW'(in_carry.gx) + FW'(in_rot_x);
        py = FW'(in_carry.gy) + FW'(in_rot_y);
      end
      OP_INVERT: begin
        px = -FW'(in_rot_x);
        py = -FW'(in_rot_y);
      end
      default: begin
        px = FW'(in_carry.gx) + FW'(in_rot_x);
        py = FW'(in_carry.gy) + FW'(in_rot_y);
      end
    endcase
    sat_x = 1'b1;
    sat_y = 1'b1;
    priority if (px > POS_MAX) begin
      rx_nxt = 32'(POS_MAX);
    end else if (px < POS_MIN) begin
      rx_nxt = 32'(POS_MIN);
    end else begin
      rx_nxt = px[31:0];
      sat_x  = 1'b0;
    end
    priority if (py > POS_MAX) begin
      ry_nxt = 32'(POS_MAX);
    end else if (py < POS_MIN) begin
      ry_nxt = 32'(POS_MIN);
    end else begin
      ry_nxt = py[31:0];
      sat_y  = 1'b0;
    end
  end

  assign adv           = !valid_r || out_ready;
  assign in_ready      = adv;
  assign out_valid     = valid_r;
  assign out_rx        = rx_r;
  assign out_ry        = ry_r;
  assign out_r_right   = r_right_r;
  assign out_r_left    = r_left_r;
  assign out_saturated = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      rx_r      <= rx_nxt;
      ry_r      <= ry_nxt;
      r_right_r <= in_carry.r_right;
      r_left_r  <= in_carry.r_left;
      sat_r     <= sat_x || sat_y;
    end
  end

endmodule

// ===== rtl/planar_pose_compose_invert.sv =====
// ----------------------------------------------------------------------------
// planar_pose_compose_invert
// pipelined pose composition and inversion with a cordic chain for the heading
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries opcode, pose g and pose h; a
//   transfer happens when both are high. result channel out_valid/out_ready
//   carries rx, ry, r_right, r_left and the saturated flag.
//   from input transfer to out_valid an item passes the register of each cordic
//   cell, then the product, rounding and saturation stages. throughput is one
//   item per cycle while the receiver does not stall, set by the cordic cell
//   row where each cell does one iteration.
//   every stage holds its own valid bit and advances when empty or when the
//   next stage advances, so bubbles close up while the receiver stalls and
//   in_ready drops only once the whole pipe is full.
//   reset clears all valid bits; no item is in flight after it.
//   no state is kept between items.
// ----------------------------------------------------------------------------
module planar_pose_compose_invert (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [0:0]         in_opcode,
  input  logic signed [31:0] in_gx,
  input  logic signed [31:0] in_gy,
  input  logic [31:0]        in_g_right,
  input  logic [31:0]        in_g_left,
  input  logic signed [31:0] in_hx,
  input  logic signed [31:0] in_hy,
  input  logic [31:0]        in_h_right,
  input  logic [31:0]        in_h_left,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_rx,
  output logic signed [31:0] out_ry,
  output logic [31:0]        out_r_right,
  output logic [31:0]        out_r_left,
  output logic [0:0]         out_saturated
);
  import ppci_pkg::*;

  logic [31:0]          heading;
  rot_t                 rot0;
  carry_t               carry0;

  rot_t                 cell_rot   [N_CELLS+1];
  carry_t               cell_carry [N_CELLS+1];
  logic [N_CELLS:0]     cell_valid;
  logic [N_CELLS:0]     cell_ready;

  logic                 mul_valid;
  logic                 mul_ready;
  logic signed [PW-1:0] pca;
  logic signed [PW-1:0] psb;
  logic signed [PW-1:0] psa;
  logic signed [PW-1:0] pcb;
  carry_t               mul_carry;

  logic                 rnd_valid;
  logic                 rnd_ready;
  logic signed [RW-1:0] rot_x;
  logic signed [RW-1:0] rot_y;
  carry_t               rnd_carry;

  logic                 sat_ready;

  // heading and quadrant fold
  always_comb begin
    heading        = in_g_right - in_g_left;
    carry0.op      = op_t'(in_opcode[0]);
    carry0.flip    = heading[31] ^ heading[30];
    carry0.gx      = in_gx;
    carry0.gy      = in_gy;
    carry0.a       = (carry0.op == OP_INVERT) ? in_gx : in_hx;
    carry0.b       = (carry0.op == OP_INVERT) ? in_gy : in_hy;
    carry0.r_right = (carry0.op == OP_INVERT) ? (32'd0 - in_g_right)
                                              : (in_g_right + in_h_right);
    carry0.r_left  = (carry0.op == OP_INVERT) ? (32'd0 - in_g_left)
                                              : (in_g_left + in_h_left);
    rot0.x         = CORDIC_GAIN;
    rot0.y         = '0;
    rot0.z         = CW'($signed({heading[31] ^ carry0.flip, heading[30:0]}));
  end

  assign cell_rot[0]   = rot0;
  assign cell_carry[0] = carry0;
  assign cell_valid[0] = in_valid;
  assign in_ready      = cell_ready[0];

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    ppci_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .shift_i   (SHW'(i)),
      .atan_i    (atan_lut(SHW'(i))),
      .in_valid  (cell_valid[i]),
      .in_ready  (cell_ready[i]),
      .in_rot    (cell_rot[i]),
      .in_carry  (cell_carry[i]),
      .out_valid (cell_valid[i+1]),
      .out_ready (cell_ready[i+1]),
      .out_rot   (cell_rot[i+1]),
      .out_carry (cell_carry[i+1])
    );
  end

  assign cell_ready[N_CELLS] = mul_ready;

  ppci_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_valid[N_CELLS]),
    .in_ready  (mul_ready),
    .in_rot    (cell_rot[N_CELLS]),
    .in_carry  (cell_carry[N_CELLS]),
    .out_valid (mul_valid),
    .out_ready (rnd_ready),
    .out_pca   (pca),
    .out_psb   (psb),
    .out_psa   (psa),
    .out_pcb   (pcb),
    .out_carry (mul_carry)
  );

  ppci_round_stage u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mul_valid),
    .in_ready  (rnd_ready),
    .in_pca    (pca),
    .in_psb    (psb),
    .in_psa    (psa),
    .in_pcb    (pcb),
    .in_carry  (mul_carry),
    .out_valid (rnd_valid),
    .out_ready (sat_ready),
    .out_rot_x (rot_x),
    .out_rot_y (rot_y),
    .out_carry (rnd_carry)
  );

  ppci_sat_stage u_sat (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (rnd_valid),
    .in_ready      (sat_ready),
    .in_rot_x      (rot_x),
    .in_rot_y      (rot_y),
    .in_carry      (rnd_carry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rx        (out_rx),
    .out_ry        (out_ry),
    .out_r_right   (out_r_right),
    .out_r_left    (out_r_left),
    .out_saturated (out_saturated[0])
  );

endmodule

// ===== rtl/ppci_checker.sv =====
// ----------------------------------------------------------------------------
// ppci_checker
// port-level checks of the pose compose/invert block, bound to the top level
// ----------------------------------------------------------------------------
`include "planar_pose_compose_invert_defines.svh"

module ppci_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_rx,
  input logic signed [31:0] out_ry,
  input logic [31:0]        out_r_right,
  input logic [31:0]        out_r_left,
  input logic [0:0]         out_saturated
);

  // a stalled result holds
  `PPCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_rx) && $stable(out_ry) && $stable(out_r_right)
    && $stable(out_r_left) && $stable(out_saturated), "result changed while stalled")

  // clipping leaves a position on a bound
  `PPCI_ASSERT_IMPL(a_sat_bound, out_valid && out_saturated[0],
    out_rx == 32'sh7FFFFFFF || out_rx == 32'sh80000000
    || out_ry == 32'sh7FFFFFFF || out_ry == 32'sh80000000,
    "saturated flag without a clipped position")

  // a receiver that takes data never blocks the input
  `PPCI_ASSERT_IMPL(a_ready_flow, out_ready, in_ready, "input blocked while output drains")

  // reset empties the pipe
  `PPCI_ASSERT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind planar_pose_compose_invert ppci_checker u_ppci_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench for planar_pose_compose_invert: a table of directed pose pairs
// (zero, full-scale, saturating and quadrant-edge headings) followed by
// random compose and invert transfers, with random gaps on the input side and
// random stalls on the result side. every result is checked field by field
// against an in-order queue of expected poses, given in the table or produced by a cordic predictor.
// ----------------------------------------------------------------------------
module tb;
  import ppci_pkg::*;

  localparam int     RAND_ITEMS    = 1250;
  localparam int     HEADING_STEPS = 24;
  localparam int     DRAIN_CYCLES  = 64;
  localparam longint START_GAIN    = 64'sd652032874;
  localparam longint POS_HI        = 64'sd2147483647;
  localparam longint POS_LO        = -64'sd2147483648;
  localparam longint TURN_ATAN [30] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  typedef struct packed {
    op_t                op;
    logic signed [31:0] gx;
    logic signed [31:0] gy;
    logic [31:0]        g_right;
    logic [31:0]        g_left;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic [31:0]        h_right;
    logic [31:0]        h_left;
  } pose_pair_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [31:0]        r_right;
    logic [31:0]        r_left;
    logic               saturated;
  } pose_res_t;

  typedef struct {
    pose_pair_t stim;
    bit         known;
    pose_res_t  res;
  } dir_row_t;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [0:0]         in_opcode     = '0;
  logic signed [31:0] in_gx         = '0;
  logic signed [31:0] in_gy         = '0;
  logic [31:0]        in_g_right    = '0;
  logic [31:0]        in_g_left     = '0;
  logic signed [31:0] in_hx         = '0;
  logic signed [31:0] in_hy         = '0;
  logic [31:0]        in_h_right    = '0;
  logic [31:0]        in_h_left     = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic signed [31:0] out_rx;
  logic signed [31:0] out_ry;
  logic [31:0]        out_r_right;
  logic [31:0]        out_r_left;
  logic [0:0]         out_saturated;

  logic               steady_run    = 1'b0;
  int                 errors        = 0;
  pose_res_t          pose_q[$];
  dir_row_t           dir_rows[$];

  planar_pose_compose_invert u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_gx         (in_gx),
    .in_gy         (in_gy),
    .in_g_right    (in_g_right),
    .in_g_left     (in_g_left),
    .in_hx         (in_hx),
    .in_hy         (in_hy),
    .in_h_right    (in_h_right),
    .in_h_left     (in_h_left),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rx        (out_rx),
    .out_ry        (out_ry),
    .out_r_right   (out_r_right),
    .out_r_left    (out_r_left),
    .out_saturated (out_saturated)
  );

  always #5 clk = ~clk;

  function automatic longint round_trig(input longint v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

  function automatic logic [31:0] clip_pos(input longint v);
    if (v > POS_HI) begin
      return POS_HI[31:0];
    end else if (v < POS_LO) begin
      return POS_LO[31:0];
    end
    return v[31:0];
  endfunction

  function automatic pose_res_t predict_pose(input pose_pair_t p);
    pose_res_t   r;
    logic [31:0] head;
    bit          flip;
    longint      ang, cx, sy, dx, dy, gx, gy, hx, hy, px, py;
    int          i;
    head = p.g_right - p.g_left;
    flip = (head[31:30] == 2'b01) || (head[31:30] == 2'b10);
    if (flip) begin
      head = head + 32'h8000_0000;
    end
    ang = $signed(head);
    cx  = START_GAIN;
    sy  = 0;
    for (i = 0; i < HEADING_STEPS; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx  = cx - dx;
        sy  = sy + dy;
        ang = ang - TURN_ATAN[i];
      end else begin
        cx  = cx + dx;
        sy  = sy - dy;
        ang = ang + TURN_ATAN[i];
      end
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    gx = $signed(p.gx);
    gy = $signed(p.gy);
    hx = $signed(p.hx);
    hy = $signed(p.hy);
    if (p.op == OP_COMPOSE) begin
      px        = gx + round_trig(cx * hx - sy * hy);
      py        = gy + round_trig(sy * hx + cx * hy);
      r.r_right = p.g_right + p.h_right;
      r.r_left  = p.g_left + p.h_left;
    end else begin
      px        = -round_trig(cx * gx + sy * gy);
      py        = -round_trig(cx * gy - sy * gx);
      r.r_right = 32'd0 - p.g_right;
      r.r_left  = 32'd0 - p.g_left;
    end
    r.rx        = clip_pos(px);
    r.ry        = clip_pos(py);
    r.saturated = (px > POS_HI) || (px < POS_LO) || (py > POS_HI) || (py < POS_LO);
    return r;
  endfunction

  function automatic pose_pair_t pose_in(input op_t op, input logic [31:0] gx, gy, gr, gl,
                                         input logic [31:0] hx, hy, hr, hl);
    pose_pair_t p;
    p.op      = op;
    p.gx      = gx;
    p.gy      = gy;
    p.g_right = gr;
    p.g_left  = gl;
    p.hx      = hx;
    p.hy      = hy;
    p.h_right = hr;
    p.h_left  = hl;
    return p;
  endfunction

  function automatic pose_res_t pose_out(input logic [31:0] rx, ry, rr, rl, input logic sat);
    pose_res_t r;
    r.rx        = rx;
    r.ry        = ry;
    r.r_right   = rr;
    r.r_left    = rl;
    r.saturated = sat;
    return r;
  endfunction

  task automatic add_row(input pose_pair_t s, input bit known, input pose_res_t r);
    dir_row_t row;
    row.stim  = s;
    row.known = known;
    row.res   = r;
    dir_rows.push_back(row);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'hffff_ffff;
          3:       return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2, 3, 4: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default:    return $urandom();
    endcase
  endfunction

  function automatic pose_pair_t rand_pose();
    pose_pair_t p;
    p.op      = op_t'($urandom_range(1));
    p.gx      = rand_pos();
    p.gy      = rand_pos();
    p.hx      = rand_pos();
    p.hy      = rand_pos();
    p.g_left  = $urandom();
    p.h_right = $urandom();
    p.h_left  = $urandom();
    if ($urandom_range(3) == 0) begin
      // heading right at a quadrant boundary, give or take a couple of lsbs
      p.g_right = p.g_left + (32'($urandom_range(3)) << 30) + 32'($urandom_range(4)) - 32'd2;
    end else begin
      p.g_right = $urandom();
    end
    return p;
  endfunction

  function automatic void check_word(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      errors++;
    end
  endfunction

  task automatic send_pose(input pose_pair_t p, input pose_res_t want, input bit steady);
    steady_run <= steady;
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= p.op;
    in_gx      <= p.gx;
    in_gy      <= p.gy;
    in_g_right <= p.g_right;
    in_g_left  <= p.g_left;
    in_hx      <= p.hx;
    in_hy      <= p.hy;
    in_h_right <= p.h_right;
    in_h_left  <= p.h_left;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    pose_q.push_back(want);
  endtask

  always @(posedge clk) begin
    out_ready <= steady_run || ($urandom_range(99) >= 36);
  end

  always @(posedge clk) begin
    pose_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $display("%0t: result transfer with nothing expected, actual rx %h ry %h",
                 $time, out_rx, out_ry);
        errors++;
      end else begin
        want = pose_q.pop_front();
        check_word("rx", want.rx, out_rx);
        check_word("ry", want.ry, out_ry);
        check_word("r_right", want.r_right, out_r_right);
        check_word("r_left", want.r_left, out_r_left);
        check_word("saturated", 32'(want.saturated), 32'(out_saturated));
      end
    end
  end

  initial begin
    int         n;
    pose_pair_t p;
    // zero h position leaves g position untouched in compose, zero g position inverts to zero; angles are easy sums
    add_row(pose_in(OP_COMPOSE, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, pose_out(0, 0, 0, 0, 1'b0));
    add_row(pose_in(OP_COMPOSE, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0,
                    32'hffffffff, 32'hffffffff), 1'b1,
            pose_out(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff, 1'b0));
    add_row(pose_in(OP_COMPOSE, 32'h00010000, 32'hffff0000, 32'h40000000, 0, 0, 0,
                    32'h12345678, 32'h87654321), 1'b1,
            pose_out(32'h00010000, 32'hffff0000, 32'h52345678, 32'h87654321, 1'b0));
    add_row(pose_in(OP_COMPOSE, 1, 32'hffffffff, 32'hc0000000, 32'h40000000, 0, 0,
                    32'h80000000, 32'hc0000000), 1'b1,
            pose_out(1, 32'hffffffff, 32'h40000000, 0, 1'b0));
    add_row(pose_in(OP_INVERT, 0, 0, 32'h12345678, 32'h9abcdef0, 32'h7fffffff,
                    32'h80000000, 32'hffffffff, 32'hffffffff), 1'b1,
            pose_out(0, 0, 32'hedcba988, 32'h65432110, 1'b0));
    add_row(pose_in(OP_INVERT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, pose_out(0, 0, 0, 0, 1'b0));
    add_row(pose_in(OP_INVERT, 0, 0, 32'h80000000, 32'h80000000, 0, 0, 0, 0), 1'b1,
            pose_out(0, 0, 32'h80000000, 32'h80000000, 1'b0));
    // saturation and heading corners go through the predictor
    add_row(pose_in(OP_COMPOSE, 32'h7fffffff, 32'h7fffffff, 0, 0, 32'h7fffffff,
                    32'h7fffffff, 0, 0), 1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 32'h80000000, 32'h80000000, 0, 0, 32'h80000000,
                    32'h80000000, 0, 0), 1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 32'h7fffffff, 0, 32'h80000000, 0, 32'h80000000, 0, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_INVERT, 32'h80000000, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(pose_in(OP_INVERT, 32'h80000000, 32'h80000000, 32'h20000000, 0, 0, 0, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_INVERT, 32'h7fffffff, 32'h80000000, 32'h60000000, 0, 0, 0, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_INVERT, 32'h00010000, 32'h00020000, 32'hffffffff, 1, 1, 2, 3, 4),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 0, 0, 32'h3fffffff, 0, 32'h00010000, 32'h00020000, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 0, 0, 32'h40000000, 0, 32'h00010000, 32'h00020000, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 0, 0, 32'h7fffffff, 0, 32'h00010000, 32'h00020000, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 0, 0, 32'hbfffffff, 0, 32'h00010000, 32'h00020000, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 0, 0, 32'hc0000000, 0, 32'h00010000, 32'h00020000, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 0, 0, 32'hffffffff, 0, 32'h00010000, 32'h00020000, 0, 0),
            1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 32'hffffffff, 32'h00000001, 32'h00000001, 32'hffffffff,
                    32'h7fffffff, 32'h80000000, 32'hffffffff, 32'hffffffff), 1'b0, '0);
    add_row(pose_in(OP_COMPOSE, 32'h80000000, 32'h7fffffff, 32'h55555555, 32'haaaaaaaa,
                    32'h80000000, 32'h7fffffff, 32'haaaaaaaa, 32'h55555555), 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) begin
      send_pose(dir_rows[k].stim,
                dir_rows[k].known ? dir_rows[k].res : predict_pose(dir_rows[k].stim), 1'b0);
    end
    for (n = 0; n < RAND_ITEMS; n++) begin
      p = rand_pose();
      send_pose(p, predict_pose(p), (n >= 400) && (n < 600));
    end
    in_valid <= 1'b0;

    while (pose_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("planar_pose_compose_invert test passed");
    end else begin
      $display("planar_pose_compose_invert test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("planar_pose_compose_invert test failed");
    $finish;
  end

endmodule
